@@ design/tcpu_pkg.sv @@
// Shared types, constants and helper functions for the teaching CPU execute unit.
// This package has no dependencies and is imported by every module of the block.
package tcpu_pkg;

  // Operation codes as they arrive with each decoded instruction.
  typedef enum logic [2:0] {
    OP_LOAD_MEM  = 3'd0,
    OP_LOAD_IMM  = 3'd1,
    OP_STORE     = 3'd2,
    OP_MOVE      = 3'd3,
    OP_ADD_TWOS  = 3'd4,
    OP_ADD_FLOAT = 3'd5,
    OP_JUMP      = 3'd6,
    OP_NOP       = 3'd7
  } op_e;

  localparam int ByteW   = 8;
  localparam int RegIdxW = 4;
  // Signed fixed point with 8 fraction bits: magnitude up to 3968 per operand,
  // so a sum needs 13 magnitude bits plus a sign.
  localparam int MagW    = 13;
  localparam int FixW    = MagW + 1;
  // Shift count of the normalizer; it never goes above 8.
  localparam int ShCntW  = 4;

  // Request to the float adder.
  typedef struct packed {
    logic             start;
    logic [ByteW-1:0] op_a;
    logic [ByteW-1:0] op_b;
  } fadd_req_t;

  // Response from the float adder.
  typedef struct packed {
    logic             done;
    logic [ByteW-1:0] result;
  } fadd_rsp_t;

  // Convert an 8-bit float (sign, 3-bit exponent, 4-bit mantissa with a hidden
  // one) exactly into signed fixed point with 8 fraction bits.
  function automatic logic signed [FixW-1:0] f8_to_fixed(input logic [ByteW-1:0] f);
    logic [MagW-1:0] mag;
    logic [FixW-1:0] ext;
    mag = MagW'({1'b1, f[3:0]}) << f[6:4];
    ext = {1'b0, mag};
    return f[7] ? $signed(-ext) : $signed(ext);
  endfunction

endpackage

@@ design/teaching_cpu_execute_unit.sv @@
// Execute unit of a small 8-bit teaching processor: one decoded instruction per request.
// Each request passes through register read, execute and retire into the output register;
// a float add also waits for the one-bit-per-cycle normalizing shifter (up to 8 shifts).
// A new request is accepted only once the previous one has retired.
// Reset returns the sequencer to idle and clears the output register at once; register-file registers then read zero.
// Depends on tcpu_pkg, tcpu_regfile and tcpu_fadd.
module teaching_cpu_execute_unit
  import tcpu_pkg::*;
#(
  parameter int REG_COUNT = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         operation_i,
  input  logic [RegIdxW-1:0] reg_a_i,
  input  logic [RegIdxW-1:0] reg_b_i,
  input  logic [RegIdxW-1:0] reg_c_i,
  input  logic [ByteW-1:0]   mem_address_i,
  input  logic [ByteW-1:0]   memory_data_i,
  input  logic [ByteW-1:0]   immediate_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               mem_write_o,
  output logic [ByteW-1:0]   write_address_o,
  output logic [ByteW-1:0]   write_data_o,
  output logic               jump_taken_o,
  output logic [ByteW-1:0]   jump_target_o,
  output logic               halt_o,
  output logic               reg_written_o,
  output logic [ByteW-1:0]   reg_value_o
);

  localparam logic [RegIdxW:0] RegLimit = (RegIdxW + 1)'(REG_COUNT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_FP,
    S_DONE
  } state_e;

  state_e state_q;

  // Latched request fields.
  op_e                op_q;
  logic [RegIdxW-1:0] ra_q;
  logic [RegIdxW-1:0] rb_q;
  logic [RegIdxW-1:0] rc_q;
  logic [ByteW-1:0]   addr_q;
  logic [ByteW-1:0]   mdata_q;
  logic [ByteW-1:0]   imm_q;

  // Pending result, waiting for the output register.
  logic               p_memw_q;
  logic [ByteW-1:0]   p_waddr_q;
  logic [ByteW-1:0]   p_wdata_q;
  logic               p_jt_q;
  logic [ByteW-1:0]   p_jtarget_q;
  logic               p_halt_q;
  logic               p_rwr_q;
  logic [ByteW-1:0]   p_rval_q;
  logic [RegIdxW-1:0] p_dst_q;

  // Result of the execute step, loaded into the pending result.
  logic               p_memw_d;
  logic [ByteW-1:0]   p_waddr_d;
  logic [ByteW-1:0]   p_wdata_d;
  logic               p_jt_d;
  logic [ByteW-1:0]   p_jtarget_d;
  logic               p_halt_d;
  logic               p_rwr_d;
  logic [ByteW-1:0]   p_rval_d;
  logic [RegIdxW-1:0] p_dst_d;

  // Output register.
  logic               out_valid_q;
  logic               memw_q;
  logic [ByteW-1:0]   waddr_q;
  logic [ByteW-1:0]   wdata_q;
  logic               jt_q;
  logic [ByteW-1:0]   jtarget_q;
  logic               halt_q;
  logic               rwr_q;
  logic [ByteW-1:0]   rval_q;

  logic [RegIdxW-1:0] rd_addr_a;
  logic [RegIdxW-1:0] rd_addr_b;
  logic [ByteW-1:0]   rd_data_a;
  logic [ByteW-1:0]   rd_data_b;
  logic               out_free;
  logic               rf_we;
  fadd_req_t          fadd_req;
  fadd_rsp_t          fadd_rsp;

  // Read port A serves the source of store, move and jump, else the first
  // add operand; port B serves register 0 for a jump, else the second operand.
  always_comb begin
    if (op_q == OP_STORE || op_q == OP_MOVE || op_q == OP_JUMP) begin
      rd_addr_a = ra_q;
    end else begin
      rd_addr_a = rb_q;
    end
    rd_addr_b = (op_q == OP_JUMP) ? '0 : rc_q;
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign rf_we      = (state_q == S_DONE) && out_free && p_rwr_q;
  assign in_ready_o = (state_q == S_IDLE);

  assign fadd_req.start = (state_q == S_EXEC) && (op_q == OP_ADD_FLOAT);
  assign fadd_req.op_a  = rd_data_a;
  assign fadd_req.op_b  = rd_data_b;

  tcpu_regfile #(
    .REG_COUNT(REG_COUNT)
  ) u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_a_i(rd_addr_a),
    .rd_addr_b_i(rd_addr_b),
    .rd_data_a_o(rd_data_a),
    .rd_data_b_o(rd_data_b),
    .wr_en_i    (rf_we),
    .wr_addr_i  (p_dst_q),
    .wr_data_i  (p_rval_q)
  );

  tcpu_fadd u_fadd (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (fadd_req),
    .rsp_o (fadd_rsp)
  );

  // Outcome of every operation except the float add, which finishes in the adder.
  always_comb begin
    p_memw_d    = 1'b0;
    p_waddr_d   = '0;
    p_wdata_d   = '0;
    p_jt_d      = 1'b0;
    p_jtarget_d = '0;
    p_halt_d    = 1'b0;
    p_rwr_d     = 1'b0;
    p_rval_d    = '0;
    p_dst_d     = ra_q;
    case (op_q)
      OP_LOAD_MEM: begin
        p_rwr_d  = ({1'b0, ra_q} < RegLimit);
        p_rval_d = ({1'b0, ra_q} < RegLimit) ? mdata_q : '0;
      end
      OP_LOAD_IMM: begin
        p_rwr_d  = ({1'b0, ra_q} < RegLimit);
        p_rval_d = ({1'b0, ra_q} < RegLimit) ? imm_q : '0;
      end
      OP_STORE: begin
        p_memw_d  = 1'b1;
        p_waddr_d = addr_q;
        p_wdata_d = rd_data_a;
      end
      OP_MOVE: begin
        p_dst_d  = rb_q;
        p_rwr_d  = ({1'b0, rb_q} < RegLimit);
        p_rval_d = ({1'b0, rb_q} < RegLimit) ? rd_data_a : '0;
      end
      OP_ADD_TWOS: begin
        p_rwr_d  = ({1'b0, ra_q} < RegLimit);
        p_rval_d = ({1'b0, ra_q} < RegLimit) ? ByteW'(rd_data_a + rd_data_b) : '0;
      end
      OP_JUMP: begin
        if (rd_data_a == rd_data_b) begin
          if (!addr_q[0]) begin
            p_jt_d      = 1'b1;
            p_jtarget_d = addr_q;
          end else begin
            p_halt_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer: accept, read registers, execute, wait for the float adder if
  // needed, then retire into the output register and the register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_NOP;
      ra_q        <= '0;
      rb_q        <= '0;
      rc_q        <= '0;
      addr_q      <= '0;
      mdata_q     <= '0;
      imm_q       <= '0;
      p_memw_q    <= 1'b0;
      p_waddr_q   <= '0;
      p_wdata_q   <= '0;
      p_jt_q      <= 1'b0;
      p_jtarget_q <= '0;
      p_halt_q    <= 1'b0;
      p_rwr_q     <= 1'b0;
      p_rval_q    <= '0;
      p_dst_q     <= '0;
      out_valid_q <= 1'b0;
      memw_q      <= 1'b0;
      waddr_q     <= '0;
      wdata_q     <= '0;
      jt_q        <= 1'b0;
      jtarget_q   <= '0;
      halt_q      <= 1'b0;
      rwr_q       <= 1'b0;
      rval_q      <= '0;
    end else begin
      // The output register fills on retire and empties when the result is taken.
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= op_e'(operation_i);
            ra_q    <= reg_a_i;
            rb_q    <= reg_b_i;
            rc_q    <= reg_c_i;
            addr_q  <= mem_address_i;
            mdata_q <= memory_data_i;
            imm_q   <= immediate_i;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          p_memw_q    <= p_memw_d;
          p_waddr_q   <= p_waddr_d;
          p_wdata_q   <= p_wdata_d;
          p_jt_q      <= p_jt_d;
          p_jtarget_q <= p_jtarget_d;
          p_halt_q    <= p_halt_d;
          p_rwr_q     <= p_rwr_d;
          p_rval_q    <= p_rval_d;
          p_dst_q     <= p_dst_d;
          state_q     <= (op_q == OP_ADD_FLOAT) ? S_FP : S_DONE;
        end
        S_FP: begin
          if (fadd_rsp.done) begin
            p_rwr_q  <= ({1'b0, ra_q} < RegLimit);
            p_rval_q <= ({1'b0, ra_q} < RegLimit) ? fadd_rsp.result : '0;
            state_q  <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            memw_q      <= p_memw_q;
            waddr_q     <= p_waddr_q;
            wdata_q     <= p_wdata_q;
            jt_q        <= p_jt_q;
            jtarget_q   <= p_jtarget_q;
            halt_q      <= p_halt_q;
            rwr_q       <= p_rwr_q;
            rval_q      <= p_rval_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mem_write_o     = memw_q;
  assign write_address_o = waddr_q;
  assign write_data_o    = wdata_q;
  assign jump_taken_o    = jt_q;
  assign jump_target_o   = jtarget_q;
  assign halt_o          = halt_q;
  assign reg_written_o   = rwr_q;
  assign reg_value_o     = rval_q;

  // The float adder only answers while the sequencer waits for it.
  a_fadd_done_in_fp : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    fadd_rsp.done |-> (state_q == S_FP)
  ) else $error("float adder answered outside the wait state");

  // A result carries at most one kind of effect.
  a_single_effect : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({memw_q, jt_q, halt_q, rwr_q})
  ) else $error("result carries more than one effect");

  // A taken jump always has an even target.
  a_jump_even : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && jt_q) |-> !jtarget_q[0]
  ) else $error("taken jump with odd target");

  // A register write happens only when the result goes into a free output register.
  a_write_with_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    rf_we |=> (out_valid_q && rwr_q)
  ) else $error("register written without a matching result");

endmodule

@@ design/tcpu_regfile.sv @@
// Register file of the teaching CPU execute unit: one write port, two registered
// read ports, and per-register valid bits so that every register reads zero after reset.
// Depends on tcpu_pkg.
module tcpu_regfile
  import tcpu_pkg::*;
#(
  parameter int REG_COUNT = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [RegIdxW-1:0] rd_addr_a_i,
  input  logic [RegIdxW-1:0] rd_addr_b_i,
  output logic [ByteW-1:0]   rd_data_a_o,
  output logic [ByteW-1:0]   rd_data_b_o,
  input  logic               wr_en_i,
  input  logic [RegIdxW-1:0] wr_addr_i,
  input  logic [ByteW-1:0]   wr_data_i
);

  localparam int IdxW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [RegIdxW:0] RegLimit = (RegIdxW + 1)'(REG_COUNT);

  logic [ByteW-1:0]     mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid_q;
  logic [ByteW-1:0]     rd_data_a_q;
  logic [ByteW-1:0]     rd_data_b_q;

  logic            hit_a;
  logic            hit_b;
  logic            wr_hit;
  logic [IdxW-1:0] idx_a;
  logic [IdxW-1:0] idx_b;
  logic [IdxW-1:0] idx_w;

  // Indexes at or above the register count read as zero and ignore writes.
  assign idx_a  = rd_addr_a_i[IdxW-1:0];
  assign idx_b  = rd_addr_b_i[IdxW-1:0];
  assign idx_w  = wr_addr_i[IdxW-1:0];
  assign hit_a  = ({1'b0, rd_addr_a_i} < RegLimit) && valid_q[idx_a];
  assign hit_b  = ({1'b0, rd_addr_b_i} < RegLimit) && valid_q[idx_b];
  assign wr_hit = wr_en_i && ({1'b0, wr_addr_i} < RegLimit);

  // A register becomes valid on its first write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_hit) begin
      valid_q[idx_w] <= 1'b1;
    end
  end

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      mem[idx_w] <= wr_data_i;
    end
  end

  // Registered reads; an unwritten register reads as zero.
  always_ff @(posedge clk_i) begin
    rd_data_a_q <= hit_a ? mem[idx_a] : '0;
    rd_data_b_q <= hit_b ? mem[idx_b] : '0;
  end

  assign rd_data_a_o = rd_data_a_q;
  assign rd_data_b_o = rd_data_b_q;

endmodule

@@ design/tcpu_fadd.sv @@
// Iterative 8-bit float adder: the operands are summed in fixed point and captured on start, then a single
// right shifter normalizes one bit per cycle.
// Depends on tcpu_pkg.
module tcpu_fadd
  import tcpu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fadd_req_t req_i,
  output fadd_rsp_t rsp_o
);

  typedef enum logic {
    F_IDLE,
    F_NORM
  } fadd_state_e;

  fadd_state_e       state_q;
  logic              sign_q;
  logic [MagW-1:0]   mag_q;
  logic [ShCntW-1:0] cnt_q;
  logic              done_q;
  logic [ByteW-1:0]  result_q;

  logic signed [FixW-1:0] sum;
  logic [FixW-1:0]        abs_sum;

  // Exact fixed-point sum of both operands and its magnitude.
  assign sum     = f8_to_fixed(req_i.op_a) + f8_to_fixed(req_i.op_b);
  assign abs_sum = sum[FixW-1] ? FixW'(-sum) : FixW'(sum);

  // Shift the magnitude right until it is below 32; the shift count is the
  // biased exponent and the low four bits are the truncated mantissa.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      sign_q   <= 1'b0;
      mag_q    <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      // The answer is flagged for one cycle, together with the registered result.
      done_q <= (state_q == F_NORM) && (mag_q[MagW-1:5] == '0);
      case (state_q)
        F_IDLE: begin
          if (req_i.start) begin
            sign_q  <= sum[FixW-1];
            mag_q   <= abs_sum[MagW-1:0];
            cnt_q   <= '0;
            state_q <= F_NORM;
          end
        end
        F_NORM: begin
          if (mag_q[MagW-1:5] != '0) begin
            mag_q <= mag_q >> 1;
            cnt_q <= cnt_q + ShCntW'(1);
          end else begin
            result_q <= {sign_q, cnt_q[2:0], mag_q[3:0]};
            state_q  <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = result_q;

endmodule
